FILE: rtl/core/ole_pkg.sv
// Package for the ordered list engine: sizes, operation codes, the cell command struct
// and the controller state type. It depends on nothing; every other file imports it.
package ole_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int ACT_W    = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_READ   = 2'd2,
		ACT_DELETE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t                op;
		logic [IDX_W-1:0]        idx;
		logic [DATA_W-1:0]       value;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_CMP   = 2'd1,
		ST_APPLY = 2'd2
	} state_t;

endpackage

FILE: rtl/core/ole_cell.sv
// One storage cell of the ordered list chain: holds one element, shifts with its
// neighbors on insert and delete, and registers an equality flag. Depends on ole_pkg.
module ole_cell import ole_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_cmd_t         cmd,
	input  logic [IDX_W-1:0]  idx,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0] data,
	output logic              match
);

	logic [DATA_W-1:0] data_q;
	logic              match_q;

	// Elements at or after the insert point move one place up; those after the
	// deleted one move one place down.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_INSERT: begin
				if (idx > cmd.idx) begin
					data_q <= left_data;
				end else if (idx == cmd.idx) begin
					data_q <= cmd.value;
				end
			end
			CELL_DELETE: begin
				if (idx >= cmd.idx) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= (data_q == cmd.value);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

FILE: rtl/core/ordered_list_engine_top.sv
// Top level of the ordered list engine: request and result stream ports, the
// controller, the row of ole_cell instances and the result register. Depends on ole_pkg.
// Flow: an accepted request passes the compare and apply states, and on apply its result
// beat is loaded. A new request is taken only back in idle, which the registered per-cell
// compare of the delete search requires; a stalled result holds the apply state longer.
// Reset: arst_n clears the element count, controller and result valid; cell contents
// stay undefined and are never read before they are written.
module ordered_list_engine_top import ole_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Request beat fields from bit 0: action[1:0], position[9:2], operand_value[41:10].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	// Result beat fields from bit 0: read_value[31:0], success[32], full_reject[33],
	// element_count[38:34].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata
);

	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Request held for the whole of its processing.
	action_t           act_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  len_q, len_d;

	// Result register, which lets a new request enter while a result waits.
	logic              m_valid_q;
	logic [DATA_W-1:0] out_rv_q;
	logic              out_success_q;
	logic              out_full_q;
	logic [CNT_W-1:0]  out_len_q;

	logic              apply;
	logic              load_out;
	logic [DATA_W-1:0] rv_d;
	logic              success_d;
	logic              full_d;
	cell_cmd_t         cmd;

	logic [DATA_W-1:0] cell_data  [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	logic              hit;
	logic [IDX_W-1:0]  del_idx;
	logic [IDX_W-1:0]  ins_idx;
	logic [IDX_W-1:0]  rd_idx;
	logic [CNT_W-1:0]  last_idx;

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_q <= action_t'(s_tdata[1:0]);
			pos_q <= s_tdata[9:2];
			val_q <= s_tdata[41:10];
		end
	end

	// First element equal to the operand among the valid ones. The match flags were
	// registered during the compare cycle, with the contents unchanged since.
	always_comb begin
		hit     = 1'b0;
		del_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i] && (CNT_W'(i) < len_q)) begin
				hit     = 1'b1;
				del_idx = IDX_W'(i);
			end
		end
	end

	// An insert at or past the end becomes an append; a read past the end
	// returns the last element.
	assign last_idx = len_q - CNT_W'(1);

	always_comb begin
		if ((act_q == ACT_INSERT) && (CMP_W'(pos_q) < CMP_W'(len_q))) begin
			ins_idx = IDX_W'(pos_q);
		end else begin
			ins_idx = IDX_W'(len_q);
		end
		if (CMP_W'(pos_q) > CMP_W'(last_idx)) begin
			rd_idx = IDX_W'(last_idx);
		end else begin
			rd_idx = IDX_W'(pos_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		apply     = 1'b0;
		load_out  = 1'b0;
		rv_d      = '0;
		success_d = 1'b0;
		full_d    = 1'b0;
		cmd.op    = CELL_HOLD;
		cmd.idx   = '0;
		cmd.value = val_q;

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				apply = !m_valid_q || m_tready;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (apply) begin
			state_d  = ST_IDLE;
			load_out = 1'b1;
			unique case (act_q)
				ACT_APPEND, ACT_INSERT: begin
					if (len_q >= CNT_W'(CAPACITY)) begin
						full_d = 1'b1;
					end else begin
						cmd.op    = CELL_INSERT;
						cmd.idx   = ins_idx;
						len_d     = len_q + CNT_W'(1);
						success_d = 1'b1;
					end
				end
				ACT_READ: begin
					if (len_q != '0) begin
						rv_d      = cell_data[rd_idx];
						success_d = 1'b1;
					end
				end
				ACT_DELETE: begin
					if (hit) begin
						cmd.op    = CELL_DELETE;
						cmd.idx   = del_idx;
						len_d     = len_q - CNT_W'(1);
						success_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_rv_q      <= rv_d;
			out_success_q <= success_d;
			out_full_q    <= full_d;
			out_len_q     <= len_d;
		end
	end

	// The cell row. Cell 0 has no lower neighbor and the top cell takes back its
	// own value on a delete.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] left_in;
		logic [DATA_W-1:0] right_in;

		if (g == 0) begin : g_first
			assign left_in = val_q;
		end else begin : g_inner
			assign left_in = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_in = cell_data[g];
		end else begin : g_body
			assign right_in = cell_data[g+1];
		end

		ole_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.idx        (IDX_W'(g)),
			.left_data  (left_in),
			.right_data (right_in),
			.data       (cell_data[g]),
			.match      (cell_match[g])
		);
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, COUNT_W'(out_len_q), out_full_q, out_success_q, out_rv_q};

	// The element count never exceeds the capacity.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	// A refused insert and a success are never reported together.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(out_success_q && out_full_q))
		else $error("success and full_reject both set");

	// A refusal is only given while the list is full.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_full_q) |-> (len_q == CNT_W'(CAPACITY)))
		else $error("full_reject with list not full");

	// A nonzero read value only comes from a successful read.
	a_rv_success: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (out_rv_q != '0)) |-> out_success_q)
		else $error("read value without success");

endmodule

FILE: bench/tb.sv
// Self-checking bench for ordered_list_engine_top: request beats go in, result beats are
// checked field by field against a list predictor held in the bench.
// Depends on ole_pkg and ordered_list_engine_top from the RTL.
module tb;
	import ole_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	// Request and result layouts, first field in the lowest bits.
	typedef struct packed {
		logic [DATA_W-1:0] operand;
		logic [POS_W-1:0]  position;
		action_t           action;
	} list_req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               full_reject;
		logic               success;
		logic [DATA_W-1:0]  read_value;
	} list_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	ordered_list_engine_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Bench copy of the list contents and length.
	logic [DATA_W-1:0] list_vals [CAPACITY];
	int                list_len = 0;

	list_req_t    request_queue [$];
	list_result_t pending_results [$];
	list_req_t    drive_req;

	int burst_left = 0;
	int gap_left = 0;
	int n_queued = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_full_rejects = 0;
	int n_deletes_hit = 0;
	int n_clamped_reads = 0;
	int max_len_seen = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Computes the result of one request and updates the bench list.
	function automatic list_result_t apply_request(input list_req_t req);
		list_result_t res;
		int slot;
		int i;
		res = '0;
		case (req.action)
			ACT_APPEND, ACT_INSERT: begin
				if (list_len >= CAPACITY) begin
					res.full_reject = 1'b1;
					n_full_rejects++;
				end else begin
					slot = list_len;
					// An insert position at or past the end falls back to an append.
					if (req.action == ACT_INSERT && int'(req.position) < list_len)
						slot = int'(req.position);
					for (i = list_len; i > slot; i--)
						list_vals[i] = list_vals[i-1];
					list_vals[slot] = req.operand;
					list_len++;
					res.success = 1'b1;
				end
			end
			ACT_READ: begin
				// An empty list reports failure; a position past the end reads the last element.
				if (list_len > 0) begin
					slot = int'(req.position);
					if (slot > list_len - 1) begin
						slot = list_len - 1;
						n_clamped_reads++;
					end
					res.read_value = list_vals[slot];
					res.success = 1'b1;
				end
			end
			default: begin
				for (i = 0; i < list_len; i++) begin
					if (list_vals[i] == req.operand) begin
						for (slot = i; slot + 1 < list_len; slot++)
							list_vals[slot] = list_vals[slot+1];
						list_len--;
						res.success = 1'b1;
						n_deletes_hit++;
						break;
					end
				end
			end
		endcase
		if (list_len > max_len_seen)
			max_len_seen = list_len;
		res.count = list_len[COUNT_W-1:0];
		return res;
	endfunction

	task automatic queue_req(input action_t act, input logic [POS_W-1:0] pos,
			input logic [DATA_W-1:0] val);
		list_req_t req;
		req.action = act;
		req.position = pos;
		req.operand = val;
		request_queue.push_back(req);
		n_queued++;
	endtask

	// Waits until every queued request has had its result beat checked.
	task automatic drain();
		while (n_checked < n_queued)
			@(posedge clk);
	endtask

	// Request driver: bursts of random length with random gaps; a held beat stays put
	// until the block takes it. Each accepted beat is predicted right away, so the
	// expectations line up in acceptance order.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_results.push_back(apply_request(drive_req));
				n_accepted++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					drive_req = request_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'b0, drive_req};
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						// A third of the bursts run straight into the next one.
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver. The stall pattern is redrawn at random on a tick counter,
	// among always ready, random stalls, one-in-four ready and long stall stretches.
	int rx_tick = 0;
	int stall_mode = 0;
	list_result_t got;
	list_result_t want;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(list_result_t)-1:0];
				if (pending_results.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: result beat with nothing expected: %h", m_tdata);
				end else begin
					want = pending_results.pop_front();
					n_checked++;
					if (got.read_value !== want.read_value || got.success !== want.success ||
							got.full_reject !== want.full_reject || got.count !== want.count ||
							m_tdata[39] !== 1'b0) begin
						n_errors++;
						if (n_errors <= 10)
							$display("ERROR: beat %0d expected value=%0d ok=%b full=%b count=%0d, got value=%0d ok=%b full=%b count=%0d",
								n_checked, $signed(want.read_value), want.success,
								want.full_reject, want.count, $signed(got.read_value),
								got.success, got.full_reject, got.count);
					end
				end
			end
			rx_tick++;
			if (rx_tick % 48 == 0)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 99) >= 35);
				2: m_tready <= (rx_tick % 4 == 0);
				default: m_tready <= (rx_tick % 16 >= 10);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Fixed values that deletes hit often, extremes among them.
	logic [DATA_W-1:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
		32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0064};

	initial begin
		int phase;
		int n;
		int pick;
		action_t act;
		logic [POS_W-1:0] pos;
		logic [DATA_W-1:0] val;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty list, sole element, clamped positions, full list.
		queue_req(ACT_READ, 8'd0, 32'd0);
		queue_req(ACT_READ, 8'd255, 32'd0);
		queue_req(ACT_DELETE, 8'd0, 32'd5);
		queue_req(ACT_APPEND, 8'd0, 32'h7FFF_FFFF);
		queue_req(ACT_DELETE, 8'd0, 32'h7FFF_FFFF);
		queue_req(ACT_APPEND, 8'd0, 32'h8000_0000);
		queue_req(ACT_INSERT, 8'd0, 32'h0000_0000);
		queue_req(ACT_INSERT, 8'd255, 32'hFFFF_FFFF);
		queue_req(ACT_INSERT, 8'd1, 32'hAAAA_AAAA);
		queue_req(ACT_READ, 8'd0, 32'd0);
		queue_req(ACT_READ, 8'd200, 32'd0);
		queue_req(ACT_DELETE, 8'd0, 32'd42);
		queue_req(ACT_DELETE, 8'd0, 32'hFFFF_FFFF);
		for (n = 3; n < CAPACITY; n++)
			queue_req(ACT_APPEND, 8'($urandom_range(0, 255)), $urandom);
		queue_req(ACT_APPEND, 8'd0, 32'h5555_5555);
		queue_req(ACT_INSERT, 8'd0, 32'h7FFF_FFFF);
		// Hold the sender until the directed results are all back.
		drain();

		// Random part: phases that grow, mix and shrink the list, so it swings between
		// empty and full. Halfway the sender waits again for the list to settle.
		for (phase = 0; phase < 12; phase++) begin
			if (phase == 6)
				drain();
			for (n = 0; n < 42; n++) begin
				pick = $urandom_range(0, 99);
				case (phase % 3)
					0: act = (pick < 45) ? ACT_APPEND : (pick < 80) ? ACT_INSERT :
						(pick < 90) ? ACT_READ : ACT_DELETE;
					1: act = (pick < 25) ? ACT_APPEND : (pick < 50) ? ACT_INSERT :
						(pick < 75) ? ACT_READ : ACT_DELETE;
					default: act = (pick < 10) ? ACT_APPEND : (pick < 20) ? ACT_INSERT :
						(pick < 40) ? ACT_READ : ACT_DELETE;
				endcase
				pos = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(0, CAPACITY + 1));
				if ($urandom_range(0, 99) < ((act == ACT_DELETE) ? 85 : 60))
					val = value_pool[$urandom_range(0, 7)];
				else
					val = $urandom;
				queue_req(act, pos, val);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			n_errors++;

		$display("Checked %0d of %0d request beats; %0d full rejects, %0d deletes found a match,",
			n_checked, n_accepted, n_full_rejects, n_deletes_hit);
		$display("%0d reads clamped to the last element, longest list %0d, %0d errors.",
			n_clamped_reads, max_len_seen, n_errors);
		if (n_errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
